// ===== src/mopc_pkg.sv =====
package mopc_pkg;

  localparam int MAX_OBSTACLES = 16;
  localparam int FRACTION_BITS = 16;

  // table address and obstacle count widths
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int NB_W  = $clog2(MAX_OBSTACLES + 1);

  // fixed field widths
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 31;
  localparam int COUNT_W = 5;
  localparam int BOX_W   = 2 * VAL_W + SIZE_W;
  localparam int BALL_W  = 3 * VAL_W + SIZE_W;
  localparam int AXES    = 3;

  // request opcodes
  localparam logic [1:0] OP_WR_BOX  = 2'd0;
  localparam logic [1:0] OP_WR_BALL = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_BOX_COUNT  = 2'd0;
  localparam logic [1:0] CFG_BALL_COUNT = 2'd1;
  localparam logic [1:0] CFG_BOX_STAMP  = 2'd2;
  localparam logic [1:0] CFG_BALL_STAMP = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_SQUARE,
    ST_HALF,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_box;
    logic wr_ball;
    logic load_query;
    logic use_box;
    logic calc_time;
    logic calc_square;
    logic calc_half;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic            busy;
    logic [NB_W-1:0] nbox;
    logic [NB_W-1:0] nball;
  } dp_sts_t;

  function automatic logic signed [63:0] ext64(input logic signed [VAL_W-1:0] x);
    return {{(64 - VAL_W){x[VAL_W-1]}}, x};
  endfunction

  // clamp to signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if ((&v[63:VAL_W-1]) || !(|v[63:VAL_W-1])) begin
      r = v[VAL_W-1:0];
    end else if (v[63]) begin
      r = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W - 1){1'b1}}};
    end
    return r;
  endfunction

  // fixed-point product scaling: floor shift, then saturate
  function automatic logic signed [VAL_W-1:0] qscale(input logic signed [63:0] p);
    return sat32(p >>> FRACTION_BITS);
  endfunction

endpackage

// ===== src/mopc_ram.sv =====
module mopc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mopc_ctrl.sv =====
module mopc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [3:0]                    in_entry_index,
  input  logic [1:0]                    in_axis,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  mopc_pkg::dp_sts_t             sts,
  output mopc_pkg::ctrl_cmd_t           cmd,
  output logic [mopc_pkg::IDX_W-1:0]    rd_addr
);

  import mopc_pkg::*;

  state_t          state_r, state_nxt;
  logic [NB_W-1:0] j_r, j_nxt;
  logic [NB_W-1:0] n_r, n_nxt;
  logic            use_box_r, use_box_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_acc;
  logic            wr_ok;
  logic            out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wr_ok    = (int'(in_entry_index) < MAX_OBSTACLES) && (int'(in_axis) < AXES);

  // next state
  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    n_nxt       = n_r;
    use_box_nxt = use_box_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_opcode == OP_QUERY) begin
          state_nxt   = ST_TIME;
          j_nxt       = '0;
          use_box_nxt = (sts.nbox != '0);
          n_nxt       = (sts.nbox != '0) ? sts.nbox : sts.nball;
        end
      end
      ST_TIME: begin
        state_nxt = (n_r == '0) ? ST_DONE : ST_SQUARE;
      end
      ST_SQUARE: begin
        state_nxt = ST_HALF;
      end
      ST_HALF: begin
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        j_nxt = j_r + 1'b1;
        if (j_r + 1'b1 == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.use_box = use_box_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_box     = in_acc && (in_opcode == OP_WR_BOX) && wr_ok;
        cmd.wr_ball    = in_acc && (in_opcode == OP_WR_BALL) && wr_ok;
        cmd.load_query = in_acc && (in_opcode == OP_QUERY);
      end
      ST_TIME:   cmd.calc_time   = 1'b1;
      ST_SQUARE: cmd.calc_square = 1'b1;
      ST_HALF:   cmd.calc_half   = 1'b1;
      ST_ISSUE:  cmd.issue       = 1'b1;
      ST_DRAIN:  cmd.issue       = 1'b0;
      ST_DONE:   cmd.load_out    = out_free;
      default:   cmd.issue       = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      n_r         <= '0;
      use_box_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      use_box_r   <= use_box_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign rd_addr   = j_r[IDX_W-1:0];
  assign out_valid = out_valid_r;

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (j_r < n_r))
    else $error("issue index past obstacle count");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == OP_QUERY) |=> (state_r == ST_TIME))
    else $error("query accepted without starting");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !sts.busy)
    else $error("result taken while pipeline busy");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("query finished without a result");

endmodule

// ===== src/mopc_dp.sv =====
module mopc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mopc_pkg::ctrl_cmd_t           cmd,
  output mopc_pkg::dp_sts_t             sts,
  input  logic [mopc_pkg::IDX_W-1:0]    rd_addr,
  input  logic [3:0]                    in_entry_index,
  input  logic [1:0]                    in_axis,
  input  logic signed [31:0]            in_center_value,
  input  logic signed [31:0]            in_velocity_value,
  input  logic signed [31:0]            in_accel_value,
  input  logic [30:0]                   in_size_value,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_point_z,
  input  logic [31:0]                   in_query_time,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_is_safe
);

  import mopc_pkg::*;

  logic [COUNT_W-1:0] box_count_r, ball_count_r;
  logic [VAL_W-1:0]   box_stamp_r, ball_stamp_r;

  logic signed [VAL_W-1:0] pt_r [AXES];
  logic [VAL_W-1:0]        qtime_r;
  logic signed [VAL_W-1:0] t_r;
  logic signed [63:0]      tt_r;
  logic signed [VAL_W-1:0] h_r;
  logic signed [VAL_W:0]   tdiff;
  logic signed [VAL_W-1:0] tsq;

  logic [BOX_W-1:0]  box_rd  [AXES];
  logic [BALL_W-1:0] ball_rd [AXES];

  logic signed [VAL_W-1:0] c_sel [AXES];
  logic signed [VAL_W-1:0] v_sel [AXES];
  logic signed [VAL_W-1:0] a_sel [AXES];
  logic [SIZE_W-1:0]       s_sel [AXES];

  logic [3:0]              v_r;
  logic signed [63:0]      prod_v_r [AXES];
  logic signed [63:0]      prod_a_r [AXES];
  logic signed [VAL_W-1:0] c_s1_r   [AXES];
  logic [SIZE_W-1:0]       s_s1_r   [AXES];
  logic signed [VAL_W-1:0] c1_r     [AXES];
  logic signed [VAL_W-1:0] q2_r     [AXES];
  logic [SIZE_W-1:0]       s_s2_r   [AXES];
  logic signed [VAL_W-1:0] ct_r     [AXES];
  logic [SIZE_W-1:0]       s_s3_r   [AXES];

  logic signed [VAL_W:0]   delta    [AXES];
  logic [VAL_W:0]          adist    [AXES];
  logic [AXES-1:0]         axis_hit;
  logic                    hit_r;
  logic                    out_is_safe_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r  <= '0;
      ball_count_r <= '0;
      box_stamp_r  <= '0;
      ball_stamp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_COUNT:  box_count_r  <= cfg_data[COUNT_W-1:0];
        CFG_BALL_COUNT: ball_count_r <= cfg_data[COUNT_W-1:0];
        CFG_BOX_STAMP:  box_stamp_r  <= cfg_data;
        CFG_BALL_STAMP: ball_stamp_r <= cfg_data;
        default:        box_stamp_r  <= box_stamp_r;
      endcase
    end
  end

  always_comb begin
    sts.nbox  = (int'(box_count_r) > MAX_OBSTACLES) ? NB_W'(MAX_OBSTACLES)
                                                     : NB_W'(box_count_r);
    sts.nball = (int'(ball_count_r) > MAX_OBSTACLES) ? NB_W'(MAX_OBSTACLES)
                                                      : NB_W'(ball_count_r);
    sts.busy  = |v_r;
  end

  // per-query setup: elapsed time, then t^2/2
  assign tdiff = $signed({1'b0, qtime_r}) -
                 $signed({1'b0, (cmd.use_box ? box_stamp_r : ball_stamp_r)});
  assign tsq   = qscale(tt_r);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      pt_r[0] <= in_point_x;
      pt_r[1] <= in_point_y;
      pt_r[2] <= in_point_z;
      qtime_r <= in_query_time;
    end
    if (cmd.calc_time) begin
      t_r <= sat32({{(63 - VAL_W){tdiff[VAL_W]}}, tdiff});
    end
    if (cmd.calc_square) begin
      tt_r <= t_r * t_r;
    end
    if (cmd.calc_half) begin
      h_r <= {1'b0, tsq[VAL_W-1:1]};
    end
  end

  // one RAM per axis and table, addressed by entry
  for (genvar k = 0; k < AXES; k++) begin : g_axis
    mopc_ram #(.WIDTH(BOX_W), .DEPTH(MAX_OBSTACLES)) u_box_ram (
      .clk   (clk),
      .we    (cmd.wr_box && (in_axis == 2'(k))),
      .waddr (IDX_W'(in_entry_index)),
      .wdata ({in_center_value, in_velocity_value, in_size_value}),
      .re    (cmd.issue),
      .raddr (rd_addr),
      .rdata (box_rd[k])
    );

    mopc_ram #(.WIDTH(BALL_W), .DEPTH(MAX_OBSTACLES)) u_ball_ram (
      .clk   (clk),
      .we    (cmd.wr_ball && (in_axis == 2'(k))),
      .waddr (IDX_W'(in_entry_index)),
      .wdata ({in_center_value, in_velocity_value, in_accel_value, in_size_value}),
      .re    (cmd.issue),
      .raddr (rd_addr),
      .rdata (ball_rd[k])
    );
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      if (cmd.use_box) begin
        c_sel[k] = $signed(box_rd[k][BOX_W-1 -: VAL_W]);
        v_sel[k] = $signed(box_rd[k][SIZE_W +: VAL_W]);
        a_sel[k] = '0;
        s_sel[k] = box_rd[k][SIZE_W-1:0];
      end else begin
        c_sel[k] = $signed(ball_rd[k][BALL_W-1 -: VAL_W]);
        v_sel[k] = $signed(ball_rd[k][SIZE_W + VAL_W +: VAL_W]);
        a_sel[k] = $signed(ball_rd[k][SIZE_W +: VAL_W]);
        s_sel[k] = ball_rd[k][SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], cmd.issue};
    end
  end

  // products, then c + t*v and h*a, then the sum
  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      prod_v_r[k] <= t_r * v_sel[k];
      prod_a_r[k] <= h_r * a_sel[k];
      c_s1_r[k]   <= c_sel[k];
      s_s1_r[k]   <= s_sel[k];

      c1_r[k]     <= sat32(ext64(c_s1_r[k]) + ext64(qscale(prod_v_r[k])));
      q2_r[k]     <= qscale(prod_a_r[k]);
      s_s2_r[k]   <= s_s1_r[k];

      ct_r[k]     <= sat32(ext64(c1_r[k]) + ext64(q2_r[k]));
      s_s3_r[k]   <= s_s2_r[k];
    end
  end

  // strict containment test: 2*|ct - p| < size
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      delta[k]    = {ct_r[k][VAL_W-1], ct_r[k]} - {pt_r[k][VAL_W-1], pt_r[k]};
      adist[k]    = delta[k][VAL_W] ? (VAL_W + 1)'(-delta[k]) : delta[k];
      axis_hit[k] = {adist[k], 1'b0} < {3'b000, s_s3_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load_query) begin
      hit_r <= 1'b0;
    end else if (v_r[3] && (&axis_hit)) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_is_safe_r <= !hit_r;
    end
  end

  assign out_is_safe = out_is_safe_r;

endmodule

// ===== src/moving_obstacle_point_check_core.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// in       | in_valid / in_stall     | opcode, entry, axis, center/vel/accel/size, point, time
// out      | out_valid / out_stall   | is_safe (one per query request)
// cfg      | cfg_valid / cfg_ready   | cfg_index (0..3), cfg_data
//
// Write and no-op requests do not stall the request channel; table writes land in the accept cycle.
// After a query is accepted in_stall stays high through three setup steps (elapsed time,
//   t*t, t*t/2), one table read per obstacle of the clamped active count n, the drain of
//   the 4-stage test pipeline and the result load (when n is 0 the elapsed time step goes
//   straight to the result load); longer while a previous result is still held.
// All three axes of an obstacle are read and tested together in the same cycle.
// Reset is synchronous; the tables are not cleared and must be written before use.
// in_stall is high from query accept until its result is in the output register;
//   a held result does not block write requests.
module moving_obstacle_point_check_core (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_entry_index,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_center_value,
  input  logic signed [31:0] in_velocity_value,
  input  logic signed [31:0] in_accel_value,
  input  logic [30:0]        in_size_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [31:0]        in_query_time,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_safe,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import mopc_pkg::*;

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] rd_addr;

  // the user must issue config writes only while idle; the block does not enforce this and always takes them
  assign cfg_ready = 1'b1;

  // sequencer: accept, setup, per-obstacle read issue, drain, result
  mopc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_axis        (in_axis),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd),
    .rd_addr        (rd_addr)
  );

  // tables, config registers, prediction pipeline and hit accumulate
  mopc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .rd_addr           (rd_addr),
    .in_entry_index    (in_entry_index),
    .in_axis           (in_axis),
    .in_center_value   (in_center_value),
    .in_velocity_value (in_velocity_value),
    .in_accel_value    (in_accel_value),
    .in_size_value     (in_size_value),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_query_time     (in_query_time),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_is_safe       (out_is_safe)
  );

endmodule
